### rtl/core/tfac_pkg.sv
package tfac_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned SpanW  = 16;
  localparam int unsigned LevelW = 7;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [LevelW-1:0] FullLevel   = LevelW'(100);
  localparam logic [7:0]        FullLevelIn = 8'd100;

  // func codes
  localparam logic [2:0] FuncTick   = 3'd0;
  localparam logic [2:0] FuncHold   = 3'd1;
  localparam logic [2:0] FuncRemote = 3'd2;
  localparam logic [2:0] FuncManual = 3'd3;
  localparam logic [2:0] FuncFood   = 3'd4;
  localparam logic [2:0] FuncWater  = 3'd5;

  // cmd codes
  localparam logic [1:0] CmdOff = 2'd0;
  localparam logic [1:0] CmdOn  = 2'd1;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgGatePeriod   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGateOpen     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRemoteTmo    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgValvePeriod  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgValveOpen    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgManualShut   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgDose         = 3'd6;

  typedef struct packed {
    logic [2:0]       func;
    logic [TimeW-1:0] now_ms;
    logic [1:0]       cmd_code;
    logic             level_reset;
    logic [7:0]       level_value;
  } in_beat_t;

  typedef struct packed {
    logic              gate_open;
    logic              valve_open;
    logic [LevelW-1:0] food_left;
    logic [LevelW-1:0] water_left;
    logic              food_report;
    logic              water_report;
    logic              shutoff_report;
  } out_beat_t;

  function automatic logic [LevelW-1:0] take_dose(input logic [LevelW-1:0] level,
                                                  input logic [LevelW-1:0] dose);
    return (level >= dose) ? (level - dose) : '0;
  endfunction

  // wrapping time difference against a 16-bit span
  function automatic logic elapsed(input logic [TimeW-1:0] now,
                                   input logic [TimeW-1:0] start,
                                   input logic [SpanW-1:0] span);
    logic [TimeW-1:0] diff;
    diff = now - start;
    return diff >= TimeW'(span);
  endfunction

endpackage

### rtl/core/timed_feeder_actuator_controller_core.sv
// A beat accepted into the input register passes to the output register that drives out_data
// as soon as the output register is not still holding a stalled beat.
// Throughput: one beat per cycle while out_stall is low; all per-beat work is one pass of logic
// between the input register and the output register.
// Reset (rst_n, synchronous, active low): registers back to defaults, gate and
// valve closed, both levels full, pipeline empty.
module timed_feeder_actuator_controller_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tfac_pkg::in_beat_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tfac_pkg::out_beat_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tfac_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tfac_pkg::SpanW-1:0] cfg_data
);
  import tfac_pkg::*;

  logic [SpanW-1:0]  gate_period_r, gate_open_ms_r, remote_tmo_r;
  logic [SpanW-1:0]  valve_period_r, valve_open_ms_r, manual_shut_r;
  logic [LevelW-1:0] dose_r;

  logic              gate_r, valve_r, hold_r, remote_r, manual_r, pend_r;
  logic [TimeW-1:0]  gate_start_r, valve_start_r, manual_start_r;
  logic [LevelW-1:0] food_r, water_r;

  logic              gate_nxt, valve_nxt, hold_nxt, remote_nxt, manual_nxt, pend_nxt;
  logic [TimeW-1:0]  gate_start_nxt, valve_start_nxt, manual_start_nxt;
  logic [LevelW-1:0] food_nxt, water_nxt;
  logic              rep_food, rep_water, rep_shut;

  logic              s1_valid_r;
  in_beat_t          s1_data_r;
  logic              out_valid_r;
  out_beat_t         out_data_r;
  out_beat_t         rslt;

  logic s1_adv, in_accept, s1_fire;
  logic gate_opened, valve_opened;

  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    gate_nxt         = gate_r;
    valve_nxt        = valve_r;
    hold_nxt         = hold_r;
    remote_nxt       = remote_r;
    manual_nxt       = manual_r;
    pend_nxt         = pend_r;
    gate_start_nxt   = gate_start_r;
    valve_start_nxt  = valve_start_r;
    manual_start_nxt = manual_start_r;
    food_nxt         = food_r;
    water_nxt        = water_r;
    rep_food         = 1'b0;
    rep_water        = 1'b0;
    rep_shut         = 1'b0;
    gate_opened      = 1'b0;
    valve_opened     = 1'b0;

    unique case (s1_data_r.func)
      FuncTick: begin
        if (!hold_r && !remote_r) begin
          if (!gate_r && elapsed(s1_data_r.now_ms, gate_start_r, gate_period_r)) begin
            gate_nxt       = 1'b1;
            gate_opened    = 1'b1;
            food_nxt       = take_dose(food_r, dose_r);
            rep_food       = 1'b1;
            gate_start_nxt = s1_data_r.now_ms;
          end
          // a gate opened this tick has zero elapsed time
          if (gate_nxt && (gate_opened ? (gate_open_ms_r == '0)
              : elapsed(s1_data_r.now_ms, gate_start_r, gate_open_ms_r)))
            gate_nxt = 1'b0;
        end
        if (remote_r && elapsed(s1_data_r.now_ms, gate_start_r, remote_tmo_r)) begin
          gate_nxt   = 1'b0;
          remote_nxt = 1'b0;
        end
        if (pend_r && elapsed(s1_data_r.now_ms, manual_start_r, manual_shut_r)) begin
          valve_nxt = 1'b0;
          pend_nxt  = 1'b0;
          rep_shut  = 1'b1;
        end
        if (!manual_r) begin
          if (!valve_nxt && elapsed(s1_data_r.now_ms, valve_start_r, valve_period_r)) begin
            valve_nxt       = 1'b1;
            valve_opened    = 1'b1;
            water_nxt       = take_dose(water_r, dose_r);
            rep_water       = 1'b1;
            valve_start_nxt = s1_data_r.now_ms;
          end
          if (valve_nxt && (valve_opened ? (valve_open_ms_r == '0)
              : elapsed(s1_data_r.now_ms, valve_start_r, valve_open_ms_r)))
            valve_nxt = 1'b0;
        end
      end
      FuncHold: begin
        if (s1_data_r.cmd_code == CmdOn) begin
          hold_nxt = 1'b1;
          gate_nxt = 1'b0;
        end else if (s1_data_r.cmd_code == CmdOff) begin
          hold_nxt = 1'b0;
        end
      end
      FuncRemote: begin
        if (s1_data_r.cmd_code == CmdOn && !gate_r && !hold_r) begin
          remote_nxt     = 1'b1;
          gate_nxt       = 1'b1;
          food_nxt       = take_dose(food_r, dose_r);
          rep_food       = 1'b1;
          gate_start_nxt = s1_data_r.now_ms;
        end else if (s1_data_r.cmd_code == CmdOff && remote_r) begin
          gate_nxt   = 1'b0;
          remote_nxt = 1'b0;
        end
      end
      FuncManual: begin
        if (s1_data_r.cmd_code == CmdOn) begin
          manual_nxt       = 1'b1;
          valve_nxt        = 1'b1;
          water_nxt        = take_dose(water_r, dose_r);
          rep_water        = 1'b1;
          manual_start_nxt = s1_data_r.now_ms;
          pend_nxt         = 1'b1;
        end else if (s1_data_r.cmd_code == CmdOff) begin
          manual_nxt = 1'b0;
          valve_nxt  = 1'b0;
        end
      end
      FuncFood: begin
        if (s1_data_r.level_reset) begin
          food_nxt = FullLevel;
          rep_food = 1'b1;
        end else if (s1_data_r.level_value <= FullLevelIn) begin
          food_nxt = s1_data_r.level_value[LevelW-1:0];
          rep_food = 1'b1;
        end
      end
      FuncWater: begin
        if (s1_data_r.level_reset) begin
          water_nxt = FullLevel;
          rep_water = 1'b1;
        end else if (s1_data_r.level_value <= FullLevelIn) begin
          water_nxt = s1_data_r.level_value[LevelW-1:0];
          if (s1_data_r.level_value == FullLevelIn)
            manual_nxt = 1'b0;
          rep_water = 1'b1;
        end
      end
      default: ;
    endcase

    rslt.gate_open      = gate_nxt;
    rslt.valve_open     = valve_nxt;
    rslt.food_left      = food_nxt;
    rslt.water_left     = water_nxt;
    rslt.food_report    = rep_food;
    rslt.water_report   = rep_water;
    rslt.shutoff_report = rep_shut;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_period_r   <= SpanW'(5000);
      gate_open_ms_r  <= SpanW'(1000);
      remote_tmo_r    <= SpanW'(1000);
      valve_period_r  <= SpanW'(10000);
      valve_open_ms_r <= SpanW'(2000);
      manual_shut_r   <= SpanW'(1000);
      dose_r          <= LevelW'(10);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgGatePeriod:  gate_period_r   <= cfg_data;
        CfgGateOpen:    gate_open_ms_r  <= cfg_data;
        CfgRemoteTmo:   remote_tmo_r    <= cfg_data;
        CfgValvePeriod: valve_period_r  <= cfg_data;
        CfgValveOpen:   valve_open_ms_r <= cfg_data;
        CfgManualShut:  manual_shut_r   <= cfg_data;
        CfgDose:        dose_r          <= cfg_data[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r         <= 1'b0;
      valve_r        <= 1'b0;
      hold_r         <= 1'b0;
      remote_r       <= 1'b0;
      manual_r       <= 1'b0;
      pend_r         <= 1'b0;
      gate_start_r   <= '0;
      valve_start_r  <= '0;
      manual_start_r <= '0;
      food_r         <= FullLevel;
      water_r        <= FullLevel;
    end else if (s1_fire) begin
      gate_r         <= gate_nxt;
      valve_r        <= valve_nxt;
      hold_r         <= hold_nxt;
      remote_r       <= remote_nxt;
      manual_r       <= manual_nxt;
      pend_r         <= pend_nxt;
      gate_start_r   <= gate_start_nxt;
      valve_start_r  <= valve_start_nxt;
      manual_start_r <= manual_start_nxt;
      food_r         <= food_nxt;
      water_r        <= water_nxt;
    end
  end

  // input register and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept)
        s1_valid_r <= 1'b1;
      else if (s1_adv)
        s1_valid_r <= 1'b0;
      if (s1_adv)
        out_valid_r <= s1_valid_r;
    end
    if (in_accept)
      s1_data_r <= in_data;
    if (s1_fire)
      out_data_r <= rslt;
  end

  a_food_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.food_left <= FullLevel && out_data_r.water_left <= FullLevel))
    else $error("level out of range");

  a_shut_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && rslt.shutoff_report) |=> !pend_r)
    else $error("shut-off pending not cleared");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("stall with empty input register");

  a_hold_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_data_r.func == FuncHold && s1_data_r.cmd_code == CmdOn) |=> !gate_r)
    else $error("gate open after hold");

endmodule
